>>> hw/rtl/rtos_priority_task_scheduler_unit_macros.svh
// Assertion macros for the task scheduler.
// Used by the top level; no other dependencies.
`ifndef RTOS_PRIORITY_TASK_SCHEDULER_UNIT_MACROS_SVH
`define RTOS_PRIORITY_TASK_SCHEDULER_UNIT_MACROS_SVH
// Implication checked on every edge outside reset.
`define RPTS_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("rpts check failed");
// Next-cycle implication.
`define RPTS_ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rpts check failed");
`endif

>>> hw/rtl/rpts_pkg.sv
// Shared types and constants for the task scheduler.
// No dependencies.
package rpts_pkg;
  localparam int NumPrios  = 32;
  localparam int IdlePrio  = 31;
  localparam int DelayBits = 16;
  localparam int PrioBits  = 5;
  localparam logic [7:0] NestMax = 8'd255;

  typedef enum logic [3:0] {
    FN_TICK = 4'd0, FN_DELAY = 4'd1, FN_ISR_ENTER = 4'd2, FN_ISR_EXIT = 4'd3,
    FN_SCHEDULE = 4'd4, FN_CREATE = 4'd5, FN_SET_STATUS = 4'd6,
    FN_SWITCH_DONE = 4'd7, FN_START = 4'd8
  } func_t;

  typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_DONE} state_t;

  // one step of the tick walk, sent to the shared decrement unit
  typedef struct packed {
    logic [DelayBits-1:0] count;
    logic                 eligible;
  } dec_req_t;

  typedef struct packed {
    logic [DelayBits-1:0] count;
    logic                 expired;
  } dec_rsp_t;

  function automatic logic [PrioBits-1:0] lowest_set(input logic [NumPrios-1:0] v);
    logic [PrioBits-1:0] n;
    n = '0;
    for (int i = NumPrios - 1; i >= 0; i--) begin
      if (v[i]) n = PrioBits'(i);
    end
    return n;
  endfunction
endpackage

>>> hw/rtl/rpts_dec_unit.sv
// Shared delay decrementer used once per task during a tick walk.
// Depends on rpts_pkg.
module rpts_dec_unit
  import rpts_pkg::*;
(
  input  dec_req_t req,
  output dec_rsp_t rsp
);
  always_comb begin
    rsp.count   = req.count;
    rsp.expired = 1'b0;
    if (req.eligible && req.count != '0) begin
      rsp.count   = req.count - 1'b1;
      rsp.expired = (req.count == DelayBits'(1));
    end
  end
endmodule

>>> hw/rtl/rtos_priority_task_scheduler_unit.sv
// Priority task scheduler. Non-tick items: strobe in the cycle after acceptance.
// Tick: walks tasks one per cycle through a shared decrementer, then strobes
// once the last slot is done. busy is high from acceptance through the strobe
// cycle, so a new item is taken only after the strobe; results cannot be stalled.
// rst (synchronous) clears all task flags, nesting and priorities; delay counters are not reset.
`include "rtos_priority_task_scheduler_unit_macros.svh"
module rtos_priority_task_scheduler_unit
  import rpts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [3:0]           func,
  input  logic [4:0]           task_prio,
  input  logic [15:0]          delay_ticks,
  input  logic                 pend_flag,
  input  logic                 suspend_flag,
  output logic                 done,
  output logic                 switch_request,
  output logic [4:0]           next_prio,
  output logic [4:0]           current_prio,
  output logic [31:0]          ready_map,
  output logic [7:0]           nest_level,
  output logic [31:0]          woken_mask,
  output logic [31:0]          timeout_mask,
  output logic                 status_code,
  output logic                 none_ready
);
  // delay counters live in a memory; the walk reads one slot a cycle
  logic [DelayBits-1:0] dmem [NumPrios];
  logic [NumPrios-1:0]  ready_bits, pend_bits, susp_bits, tmo_bits, created;
  logic [7:0]           nesting;
  logic [PrioBits-1:0]  running_prio, best_prio, idx;
  logic [NumPrios-1:0]  woken, tmo;
  logic                 sw, status, sw_next;
  logic [NumPrios-1:0]  rdy_wo;   // ready map without the running task
  state_t               state, state_next;
  logic [PrioBits-1:0]  ptr;      // slot being read; zero whenever idle
  logic                 rd_valid; // dmem read data for idx is present
  logic [DelayBits-1:0] rd_data;
  dec_req_t             dreq;
  dec_rsp_t             drsp;

  rpts_dec_unit u_dec (.req(dreq), .rsp(drsp));

  always_comb begin
    dreq.count    = rd_data;
    dreq.eligible = rd_valid && created[idx] && (idx != PrioBits'(IdlePrio));
  end

  assign rdy_wo = ready_bits & ~(NumPrios'(1) << running_prio);

  // switch request for the item being accepted
  always_comb begin
    sw_next = 1'b0;
    case (func)
      FN_DELAY: if (nesting == '0 && delay_ticks != '0 && rdy_wo != '0)
        sw_next = lowest_set(rdy_wo) != running_prio;
      FN_ISR_EXIT: if (nesting <= 8'd1 && ready_bits != '0)
        sw_next = lowest_set(ready_bits) != running_prio;
      FN_SCHEDULE: if (nesting == '0 && ready_bits != '0)
        sw_next = lowest_set(ready_bits) != running_prio;
      FN_START: sw_next = (ready_bits != '0);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = (func == FN_TICK) ? ST_WALK : ST_DONE;
      ST_WALK: if (rd_valid && idx == PrioBits'(NumPrios - 1)) state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);

  // memory: one read and one write port
  always_ff @(posedge clk) begin
    rd_data <= dmem[ptr];
    if (state == ST_WALK && dreq.eligible) dmem[idx] <= drsp.count;
    else if (state == ST_IDLE && start && func == FN_DELAY && nesting == '0
             && delay_ticks != '0)
      dmem[running_prio] <= delay_ticks;
    else if (state == ST_IDLE && start && func == FN_CREATE && !created[task_prio])
      dmem[task_prio] <= '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ready_bits <= '0; pend_bits <= '0; susp_bits <= '0; tmo_bits <= '0;
      created <= '0; nesting <= '0; running_prio <= '0; best_prio <= '0;
      ptr <= '0; idx <= '0; rd_valid <= 1'b0; woken <= '0; tmo <= '0;
      sw <= 1'b0; status <= 1'b0;
    end else begin
      if (state == ST_IDLE && start) begin
        woken <= '0; tmo <= '0; sw <= sw_next;
        status <= (func == FN_CREATE) && created[task_prio];
        ptr <= (func == FN_TICK) ? PrioBits'(1) : '0;
        rd_valid <= (func == FN_TICK);
        case (func)
          FN_TICK: idx <= '0;
          FN_DELAY: if (nesting == '0 && delay_ticks != '0) begin
            ready_bits[running_prio] <= 1'b0;
            if (rdy_wo != '0) best_prio <= lowest_set(rdy_wo);
          end
          FN_ISR_ENTER: if (nesting != NestMax) nesting <= nesting + 8'd1;
          FN_ISR_EXIT: begin
            if (nesting != '0) nesting <= nesting - 8'd1;
            if (nesting <= 8'd1 && ready_bits != '0) best_prio <= lowest_set(ready_bits);
          end
          FN_SCHEDULE: if (nesting == '0 && ready_bits != '0) begin
            best_prio <= lowest_set(ready_bits);
          end
          FN_CREATE: begin
            if (!created[task_prio]) begin
              created[task_prio] <= 1'b1; pend_bits[task_prio] <= 1'b0;
              susp_bits[task_prio] <= 1'b0; tmo_bits[task_prio] <= 1'b0;
              ready_bits[task_prio] <= 1'b1;
            end
          end
          FN_SET_STATUS: if (created[task_prio]) begin
            pend_bits[task_prio] <= pend_flag;
            susp_bits[task_prio] <= suspend_flag;
          end
          FN_SWITCH_DONE: running_prio <= best_prio;
          FN_START: if (ready_bits != '0) begin
            best_prio <= lowest_set(ready_bits);
            running_prio <= lowest_set(ready_bits);
          end
          default: ;
        endcase
      end else if (state == ST_WALK) begin
        if (dreq.eligible && drsp.expired) begin
          woken[idx] <= 1'b1;
          if (pend_bits[idx]) begin
            pend_bits[idx] <= 1'b0; tmo_bits[idx] <= 1'b1; tmo[idx] <= 1'b1;
          end else tmo_bits[idx] <= 1'b0;
          if (!susp_bits[idx]) ready_bits[idx] <= 1'b1;
        end
        idx <= idx + 1'b1;
        // last slot: park the read pointer on slot 0 for the next tick
        if (idx == PrioBits'(NumPrios - 1)) begin
          rd_valid <= 1'b0;
          ptr <= '0;
        end else ptr <= ptr + 1'b1;
      end
    end
  end

  assign done           = (state == ST_DONE);
  assign switch_request = sw;
  assign next_prio      = best_prio;
  assign current_prio   = running_prio;
  assign ready_map      = ready_bits;
  assign nest_level     = nesting;
  assign woken_mask     = woken;
  assign timeout_mask   = tmo;
  assign status_code    = status;
  assign none_ready     = (ready_bits == '0);

  `RPTS_ASSERT_NXT(a_done_pulse, done, !done)
  `RPTS_ASSERT_IMP(a_woken_created, done, (woken & ~created) == '0)
  `RPTS_ASSERT_IMP(a_tmo_in_woken, done, (tmo & ~woken) == '0)
  `RPTS_ASSERT_IMP(a_idle_never_wakes, done, !woken[IdlePrio])
endmodule

>>> tb/sv/rtos_priority_task_scheduler_unit_test.sv
// Self-checking testbench for the priority task scheduler unit.
// Depends on rpts_pkg and the rtos_priority_task_scheduler_unit RTL only.
module rtos_priority_task_scheduler_unit_test;
  import rpts_pkg::*;

  // one result item as seen on the output ports
  typedef struct {
    logic        sw;
    logic [4:0]  nxt;
    logic [4:0]  cur;
    logic [31:0] rdy;
    logic [7:0]  nest;
    logic [31:0] woken;
    logic [31:0] tmo;
    logic        status;
    logic        empty;
  } sched_result_t;

  // Scheduler mirror plus queue of expected results.
  class sched_scoreboard;
    logic [31:0]          rdy_bits;
    logic [DelayBits-1:0] dly [NumPrios];
    logic [NumPrios-1:0]  pend_m, susp_m, tmo_m, made_m;
    logic [7:0]           nest;
    logic [4:0]           run_prio, best;
    sched_result_t        pending_q[$];
    int                   errors;

    function new();
      rdy_bits = '0; pend_m = '0; susp_m = '0; tmo_m = '0; made_m = '0;
      nest = '0; run_prio = '0; best = '0; errors = 0;
      foreach (dly[i]) dly[i] = '0;
    endfunction

    function logic [4:0] first_ready();
      logic [4:0] n;
      n = '0;
      for (int i = NumPrios - 1; i >= 0; i--) if (rdy_bits[i]) n = i[4:0];
      return n;
    endfunction

    // picks the best ready priority; returns 1 when a switch is due
    function logic reschedule();
      if (nest != '0 || rdy_bits == '0) return 1'b0;
      best = first_ready();
      return best != run_prio;
    endfunction

    function void note_item(logic [3:0] fn, logic [4:0] pr, logic [15:0] ticks,
                            logic pf, logic sf);
      sched_result_t r;
      r.sw = 1'b0; r.woken = '0; r.tmo = '0; r.status = 1'b0;
      case (fn)
        FN_TICK: begin
          for (int p = 0; p < NumPrios; p++) begin
            if (p == IdlePrio || !made_m[p] || dly[p] == '0) continue;
            dly[p]--;
            if (dly[p] == '0) begin
              r.woken[p] = 1'b1;
              if (pend_m[p]) begin
                pend_m[p] = 1'b0; tmo_m[p] = 1'b1; r.tmo[p] = 1'b1;
              end else tmo_m[p] = 1'b0;
              if (!susp_m[p]) rdy_bits[p] = 1'b1;
            end
          end
        end
        FN_DELAY: begin
          if (nest == '0 && ticks != '0) begin
            rdy_bits[run_prio] = 1'b0;
            dly[run_prio] = ticks;
            r.sw = reschedule();
          end
        end
        FN_ISR_ENTER: if (nest != NestMax) nest++;
        FN_ISR_EXIT: begin
          if (nest != '0) nest--;
          r.sw = reschedule();
        end
        FN_SCHEDULE: r.sw = reschedule();
        FN_CREATE: begin
          if (made_m[pr]) r.status = 1'b1;
          else begin
            made_m[pr] = 1'b1; pend_m[pr] = 1'b0; susp_m[pr] = 1'b0; tmo_m[pr] = 1'b0;
            dly[pr] = '0; rdy_bits[pr] = 1'b1;
          end
        end
        FN_SET_STATUS: if (made_m[pr]) begin
          pend_m[pr] = pf; susp_m[pr] = sf;
        end
        FN_SWITCH_DONE: run_prio = best;
        FN_START: if (rdy_bits != '0) begin
          best = first_ready(); run_prio = best; r.sw = 1'b1;
        end
        default: ;
      endcase
      r.nxt = best; r.cur = run_prio; r.rdy = rdy_bits; r.nest = nest;
      r.empty = (rdy_bits == '0);
      pending_q.push_back(r);
    endfunction

    function void check_result(sched_result_t got);
      sched_result_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: result with nothing expected", $time);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (got.sw !== e.sw) bad("switch_request", e.sw, got.sw);
      if (got.nxt !== e.nxt) bad("next_prio", e.nxt, got.nxt);
      if (got.cur !== e.cur) bad("current_prio", e.cur, got.cur);
      if (got.rdy !== e.rdy) bad("ready_map", e.rdy, got.rdy);
      if (got.nest !== e.nest) bad("nest_level", e.nest, got.nest);
      if (got.woken !== e.woken) bad("woken_mask", e.woken, got.woken);
      if (got.tmo !== e.tmo) bad("timeout_mask", e.tmo, got.tmo);
      if (got.status !== e.status) bad("status_code", e.status, got.status);
      if (got.empty !== e.empty) bad("none_ready", e.empty, got.empty);
    endfunction

    function void bad(string fld, logic [31:0] exp_v, logic [31:0] act_v);
      $display("%0t: %s expected %h actual %h", $time, fld, exp_v, act_v);
      errors++;
    endfunction
  endclass

  logic        clk = 0, rst = 1, start = 0;
  logic        busy, done;
  logic [3:0]  func = '0;
  logic [4:0]  task_prio = '0;
  logic [15:0] delay_ticks = '0;
  logic        pend_flag = 0, suspend_flag = 0;
  logic        switch_request, status_code, none_ready;
  logic [4:0]  next_prio, current_prio;
  logic [31:0] ready_map, woken_mask, timeout_mask;
  logic [7:0]  nest_level;

  sched_scoreboard sb = new();
  int idle_pct = 0;

  always #6 clk = ~clk;

  rtos_priority_task_scheduler_unit uut (.*);

  // results cannot be held off: take every strobe
  always @(posedge clk) begin
    sched_result_t got;
    if (!rst && done) begin
      got.sw = switch_request; got.nxt = next_prio; got.cur = current_prio;
      got.rdy = ready_map; got.nest = nest_level; got.woken = woken_mask;
      got.tmo = timeout_mask; got.status = status_code; got.empty = none_ready;
      sb.check_result(got);
    end
  end

  // Drives one item from a falling edge and holds it until accepted.
  // A random gap may precede it, per the current idle rate.
  task automatic send_item(logic [3:0] fn, logic [4:0] pr, logic [15:0] ticks,
                           logic pf, logic sf);
    if ($urandom_range(0, 99) < idle_pct) begin
      start = 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    func = fn; task_prio = pr; delay_ticks = ticks;
    pend_flag = pf; suspend_flag = sf; start = 1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_item(fn, pr, ticks, pf, sf);
    @(negedge clk);
  endtask

  task automatic drain();
    start = 0;
    while (sb.pending_q.size() != 0) @(negedge clk);
  endtask

  task automatic random_item();
    int r;
    logic [3:0]  fn;
    logic [4:0]  pr;
    logic [15:0] t;
    logic        pf, sf;
    r  = $urandom_range(0, 99);
    pr = 5'($urandom);
    t  = 16'($urandom);
    pf = 1'($urandom);
    sf = 1'($urandom);
    if (r < 15) fn = FN_TICK;
    else if (r < 28) begin
      fn = FN_DELAY;
      case ($urandom_range(0, 9))
        0: t = '0;
        1: t = 16'($urandom);
        default: t = 16'($urandom_range(1, 4));
      endcase
    end
    else if (r < 38) fn = FN_ISR_ENTER;
    else if (r < 50) fn = FN_ISR_EXIT;
    else if (r < 60) fn = FN_SCHEDULE;
    else if (r < 68) fn = FN_CREATE;
    else if (r < 80) fn = FN_SET_STATUS;
    else if (r < 90) fn = FN_SWITCH_DONE;
    else if (r < 95) fn = FN_START;
    else fn = 4'($urandom_range(9, 15));
    send_item(fn, pr, t, pf, sf);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: empty map, create edges, duplicate, flags, nesting, delays
    send_item(FN_START, 5'd0, '0, 0, 0);
    send_item(FN_SCHEDULE, 5'd0, '0, 0, 0);
    send_item(FN_SET_STATUS, 5'd3, '0, 1, 1);      // uncreated: ignored
    send_item(FN_ISR_EXIT, 5'd0, '0, 0, 0);        // exit at zero stays zero
    send_item(FN_CREATE, 5'd31, '0, 0, 0);
    send_item(FN_CREATE, 5'd0, '0, 0, 0);
    send_item(FN_CREATE, 5'd0, '0, 0, 0);          // duplicate
    send_item(FN_CREATE, 5'd7, '0, 0, 0);
    send_item(FN_START, 5'd0, '0, 0, 0);
    send_item(FN_DELAY, 5'd0, 16'd2, 0, 0);
    send_item(FN_SWITCH_DONE, 5'd0, '0, 0, 0);
    send_item(FN_SET_STATUS, 5'd0, 16'hffff, 1, 0);
    send_item(FN_DELAY, 5'd0, 16'd0, 0, 0);        // zero delay ignored
    send_item(FN_TICK, 5'd0, '0, 0, 0);
    send_item(FN_TICK, 5'd0, '0, 0, 0);            // pend timeout on wake
    send_item(FN_DELAY, 5'd0, 16'hffff, 0, 0);
    send_item(FN_SWITCH_DONE, 5'd0, '0, 0, 0);
    send_item(FN_CREATE, 5'd4, '0, 0, 0);
    send_item(FN_SET_STATUS, 5'd4, '0, 0, 1);
    send_item(FN_ISR_ENTER, 5'd0, '0, 0, 0);
    send_item(FN_DELAY, 5'd0, 16'd1, 0, 0);        // ignored while nested
    send_item(FN_SCHEDULE, 5'd0, '0, 0, 0);
    send_item(FN_ISR_EXIT, 5'd0, '0, 0, 0);
    send_item(4'd15, 5'd31, 16'hffff, 1, 1);       // unused code

    idle_pct = 15;
    repeat (300) random_item();
    drain();                                       // sender waits for all results
    idle_pct = 52;
    repeat (300) random_item();
    drain();
    idle_pct = 0;
    // nesting saturation at the top, then unwind
    repeat (258) send_item(FN_ISR_ENTER, 5'($urandom), 16'($urandom),
                           1'($urandom), 1'($urandom));
    repeat (258) send_item(FN_ISR_EXIT, 5'($urandom), 16'($urandom),
                           1'($urandom), 1'($urandom));
    repeat (260) random_item();

    drain();
    repeat (60) @(posedge clk);
    if (sb.errors == 0) $display("rtos_priority_task_scheduler_unit regression: pass");
    else $display("rtos_priority_task_scheduler_unit regression: fail");
    $finish;
  end

  // overall watchdog
  initial begin
    #7200000;
    $display("rtos_priority_task_scheduler_unit regression: fail");
    $finish;
  end
endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/rpts_pkg.sv
hw/rtl/rpts_dec_unit.sv
hw/rtl/rtos_priority_task_scheduler_unit.sv
tb/sv/rtos_priority_task_scheduler_unit_test.sv
